// ----- hdl/b24k_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b24k_pkg
// Shared constants, types and helper functions for the base-24 key encoder:
// word layout, CRC-32 byte update, base-24 digit cells and the key alphabet.
// ----------------------------------------------------------------------------
package b24k_pkg;

	// Packed word layout
	localparam int WORD_W     = 115;
	localparam int CHK_LSB    = 103;
	localparam int CHK_W      = 10;
	localparam int CRC_BYTES  = 16;
	localparam int CRC_BITS   = CRC_BYTES * 8;

	// Base-24 conversion: three word bits enter the digit cells per step
	localparam int STEP_BITS  = 3;
	localparam int NDIG       = 25;
	localparam int DIG_W      = 5;
	localparam int CONV_STEPS = (WORD_W + STEP_BITS - 1) / STEP_BITS;
	localparam int CONV_W     = CONV_STEPS * STEP_BITS;
	localparam int STEPS_A    = (CONV_STEPS + 1) / 2;
	localparam int STEPS_B    = CONV_STEPS - STEPS_A;

	localparam int KEY_LEN    = 29;
	localparam int POS_W      = 5;
	localparam int FIFO_DEPTH = 2;

	localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// Largest word allowed when the extra flag is set
	localparam logic [WORD_W-1:0] LIMIT_WORD = {43'h62A_32B1_5518, 72'h0};

	// Output characters
	localparam logic [6:0] CH_NONE = 7'h00;
	localparam logic [6:0] CH_N    = 7'h4E;
	localparam logic [6:0] CH_DASH = 7'h2D;

	// Dash positions in the final key
	localparam logic [POS_W-1:0] DASH_0 = 5'd5;
	localparam logic [POS_W-1:0] DASH_1 = 5'd11;
	localparam logic [POS_W-1:0] DASH_2 = 5'd17;
	localparam logic [POS_W-1:0] DASH_3 = 5'd23;

	typedef logic [DIG_W-1:0] digit_t;
	typedef digit_t [NDIG-1:0] digits_t;

	typedef struct packed {
		logic              err;
		logic [WORD_W-1:0] word;
	} key_word_t;

	typedef struct packed {
		logic              err;
		logic [CONV_W-1:0] bits;
		digits_t           digits;
	} conv_item_t;

	// One byte of non-reflected CRC-32, MSB first
	function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {data, 24'h0};
		for (int i = 0; i < 8; i++) begin
			c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	// floor(d / 3) for a digit below 24
	function automatic logic [2:0] div3(digit_t d);
		logic [8:0] p;
		p = 9'(d) * 9'd11;
		return p[7:5];
	endfunction

	// Shift three bits into the base-24 cells. Each cell's carry depends only
	// on its own digit, so all cells update in parallel.
	function automatic digits_t conv_step(digits_t d, logic [STEP_BITS-1:0] din);
		digits_t    r;
		logic [2:0] cy [NDIG+1];
		digit_t     m;
		cy[0] = din;
		for (int k = 0; k < NDIG; k++) begin
			cy[k+1] = div3(d[k]);
		end
		for (int k = 0; k < NDIG; k++) begin
			m    = d[k] - 5'(cy[k+1]) * 5'd3;
			r[k] = {m[1:0], cy[k]};
		end
		return r;
	endfunction

	function automatic logic [6:0] alpha(digit_t d);
		logic [6:0] c;
		case (d)
			5'd0:    c = 7'h42;
			5'd1:    c = 7'h43;
			5'd2:    c = 7'h44;
			5'd3:    c = 7'h46;
			5'd4:    c = 7'h47;
			5'd5:    c = 7'h48;
			5'd6:    c = 7'h4A;
			5'd7:    c = 7'h4B;
			5'd8:    c = 7'h4D;
			5'd9:    c = 7'h50;
			5'd10:   c = 7'h51;
			5'd11:   c = 7'h52;
			5'd12:   c = 7'h54;
			5'd13:   c = 7'h56;
			5'd14:   c = 7'h57;
			5'd15:   c = 7'h58;
			5'd16:   c = 7'h59;
			5'd17:   c = 7'h32;
			5'd18:   c = 7'h33;
			5'd19:   c = 7'h34;
			5'd20:   c = 7'h36;
			5'd21:   c = 7'h37;
			5'd22:   c = 7'h38;
			5'd23:   c = 7'h39;
			default: c = CH_NONE;
		endcase
		return c;
	endfunction

endpackage

// ----- hdl/b24k_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b24k_front
// Accepts input transactions, packs the word, runs the CRC-32 one byte per
// cycle, inserts the check bits and flags words over the limit.
// ----------------------------------------------------------------------------
module b24k_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [19:0]                group_id,
	input  logic [29:0]                serial_number,
	input  logic [52:0]                security_value,
	input  logic                       upgrade_flag,
	input  logic                       extra_flag,
	output logic                       out_valid,
	input  logic                       out_ready,
	output b24k_pkg::key_word_t        out_item
);

	typedef enum logic [1:0] {E_IDLE, E_CRC, E_DONE} eng_state_t;

	localparam int PAD_W = b24k_pkg::CRC_BITS - b24k_pkg::WORD_W;

	eng_state_t                      state_q;
	logic                            in_full_q;
	logic [b24k_pkg::WORD_W-1:0]     in_word_q;
	logic [b24k_pkg::WORD_W-1:0]     word_q;
	logic [31:0]                     crc_q;
	logic [3:0]                      cnt_q;

	logic                            eng_take;
	logic                            accept;
	logic [b24k_pkg::CRC_BITS-1:0]   w128;
	logic [7:0]                      cur_byte;
	logic [31:0]                     crc_next;

	assign eng_take = in_full_q && (state_q == E_IDLE || (state_q == E_DONE && out_ready));
	assign in_ready = !in_full_q || eng_take;
	assign accept   = in_valid && in_ready;

	assign w128     = {{PAD_W{1'b0}}, word_q};
	assign cur_byte = w128[{cnt_q, 3'b000} +: 8];
	assign crc_next = b24k_pkg::crc_byte(crc_q, cur_byte);

	// Input holding register: take the next transaction while the CRC runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_full_q <= 1'b0;
		end else if (accept) begin
			in_full_q <= 1'b1;
		end else if (eng_take) begin
			in_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_word_q <= {extra_flag, upgrade_flag, {b24k_pkg::CHK_W{1'b0}},
				security_value, serial_number, group_id};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			cnt_q   <= '0;
			crc_q   <= '0;
			word_q  <= '0;
		end else begin
			case (state_q)
				E_IDLE: begin
					if (eng_take) begin
						word_q  <= in_word_q;
						crc_q   <= b24k_pkg::CRC_INIT;
						cnt_q   <= '0;
						state_q <= E_CRC;
					end
				end
				E_CRC: begin
					crc_q <= crc_next;
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(b24k_pkg::CRC_BYTES - 1)) begin
						word_q[b24k_pkg::CHK_LSB +: b24k_pkg::CHK_W] <=
							~crc_next[b24k_pkg::CHK_W-1:0];
						state_q <= E_DONE;
					end
				end
				E_DONE: begin
					if (eng_take) begin
						word_q  <= in_word_q;
						crc_q   <= b24k_pkg::CRC_INIT;
						cnt_q   <= '0;
						state_q <= E_CRC;
					end else if (out_ready) begin
						state_q <= E_IDLE;
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	assign out_valid     = (state_q == E_DONE);
	assign out_item.word = word_q;
	assign out_item.err  = word_q[b24k_pkg::WORD_W-1] && (word_q > b24k_pkg::LIMIT_WORD);

endmodule

// ----- hdl/b24k_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b24k_fifo
// Short queue of finished words between the front and the digit converters.
// DEPTH must be 2 or more.
// ----------------------------------------------------------------------------
module b24k_fifo #(
	parameter int DEPTH = b24k_pkg::FIFO_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  b24k_pkg::key_word_t push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output b24k_pkg::key_word_t pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	b24k_pkg::key_word_t mem [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hdl/b24k_conv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b24k_conv
// Base-24 conversion stage: shifts the word into 25 digit cells, three bits
// per cycle, for STEPS steps, then offers the partial result downstream.
// ----------------------------------------------------------------------------
module b24k_conv #(
	parameter int STEPS = b24k_pkg::STEPS_A
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  b24k_pkg::conv_item_t in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output b24k_pkg::conv_item_t out_item
);

	localparam int CNT_W = $clog2(STEPS);

	b24k_pkg::conv_item_t item_q;
	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 take;

	assign in_ready  = !busy_q && (!done_q || out_ready);
	assign take      = in_valid && in_ready;
	assign out_valid = done_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			item_q <= '0;
		end else if (take) begin
			item_q <= in_item;
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			item_q.digits <= b24k_pkg::conv_step(item_q.digits,
				item_q.bits[b24k_pkg::CONV_W-1 -: b24k_pkg::STEP_BITS]);
			item_q.bits   <= item_q.bits << b24k_pkg::STEP_BITS;
			cnt_q         <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else if (done_q && out_ready) begin
			done_q <= 1'b0;
		end
	end

endmodule

// ----- hdl/b24k_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b24k_emit
// Walks the 29 key positions of a converted word, inserting the 'N' and the
// dashes, and drives one character per output transaction, or a single empty final one for an error item.
// ----------------------------------------------------------------------------
module b24k_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  b24k_pkg::conv_item_t in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [6:0]           key_char,
	output logic                 is_last,
	output logic                 is_error
);

	b24k_pkg::digits_t            digits_q;
	logic                         err_q;
	logic                         hold_q;
	logic [b24k_pkg::POS_W-1:0]   pos_q;
	logic [b24k_pkg::DIG_W-1:0]   j_q;
	logic                         out_valid_q;
	logic [6:0]                   key_char_q;
	logic                         is_last_q;
	logic                         is_error_q;

	logic                         is_dash;
	logic                         last_c;
	logic                         produce;
	logic                         take;
	b24k_pkg::digit_t             top_d;
	logic [b24k_pkg::DIG_W-1:0]   sel_idx;
	logic [6:0]                   ch;

	assign top_d   = digits_q[b24k_pkg::NDIG-1];
	assign last_c  = err_q || (pos_q == b24k_pkg::POS_W'(b24k_pkg::KEY_LEN - 1));
	assign produce = hold_q && (!out_valid_q || out_ready);
	assign in_ready = !hold_q || (produce && last_c);
	assign take    = in_valid && in_ready;

	// Before the 'N' read digits from the top down; after it, one place later
	assign sel_idx = (j_q < top_d) ? b24k_pkg::DIG_W'(b24k_pkg::NDIG - 2) - j_q
	                               : b24k_pkg::DIG_W'(b24k_pkg::NDIG - 1) - j_q;

	always_comb begin
		is_dash = pos_q inside {b24k_pkg::DASH_0, b24k_pkg::DASH_1,
		                        b24k_pkg::DASH_2, b24k_pkg::DASH_3};
		if (err_q) begin
			ch = b24k_pkg::CH_NONE;
		end else if (is_dash) begin
			ch = b24k_pkg::CH_DASH;
		end else if (j_q == top_d) begin
			ch = b24k_pkg::CH_N;
		end else begin
			ch = b24k_pkg::alpha(digits_q[sel_idx]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q   <= 1'b0;
			err_q    <= 1'b0;
			pos_q    <= '0;
			j_q      <= '0;
			digits_q <= '0;
		end else if (take) begin
			digits_q <= in_item.digits;
			err_q    <= in_item.err;
			hold_q   <= 1'b1;
			pos_q    <= '0;
			j_q      <= '0;
		end else if (produce) begin
			if (last_c) begin
				hold_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 1'b1;
				if (!is_dash) begin
					j_q <= j_q + 1'b1;
				end
			end
		end
	end

	// Output register: hold the character until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			key_char_q  <= '0;
			is_last_q   <= 1'b0;
			is_error_q  <= 1'b0;
		end else if (produce) begin
			out_valid_q <= 1'b1;
			key_char_q  <= ch;
			is_last_q   <= last_c;
			is_error_q  <= err_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign key_char  = key_char_q;
	assign is_last   = is_last_q;
	assign is_error  = is_error_q;

endmodule

// ----- hdl/base24_key_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base24_key_encoder
// Packs group, serial, security and flag fields into a 115-bit word, adds a
// CRC-derived check field and emits the 29-character base-24 key.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one transaction of group_id,
//   serial_number, security_value, upgrade_flag and extra_flag. Output channel
//   (out_valid/out_ready) returns 29 transactions, one ASCII key_char each,
//   with is_last on the final one. If extra_flag is set and the word is over
//   the limit, a single transaction with key_char 0, is_last and is_error
//   is returned instead.
//   Path: the input holding register loads the CRC engine, which runs the
//   byte-wise CRC over 16 bytes; the word then passes the queue, the two
//   base-24 stages of 20 and 19 three-bit steps and the character stage.
//   The one-character output channel bounds the rate of keys; error items
//   are bounded by the first conversion stage. A FIFO_DEPTH-entry queue and
//   a held word in every stage let the front keep accepting while the output
//   is stalled.
//   Reset clears all handshake state; no item is in flight after reset.
//   A stalled receiver holds the current character; the stages behind it
//   fill up and in_ready drops.
// ----------------------------------------------------------------------------
module base24_key_encoder #(
	parameter int FIFO_DEPTH = b24k_pkg::FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [19:0] group_id,
	input  logic [29:0] serial_number,
	input  logic [52:0] security_value,
	input  logic        upgrade_flag,
	input  logic        extra_flag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  key_char,
	output logic        is_last,
	output logic        is_error
);

	localparam int TOP_PAD = b24k_pkg::CONV_W - b24k_pkg::WORD_W;

	logic                 f_valid;
	logic                 f_ready;
	b24k_pkg::key_word_t  f_item;
	logic                 q_valid;
	logic                 q_ready;
	b24k_pkg::key_word_t  q_item;
	b24k_pkg::conv_item_t a_in;
	logic                 a_valid;
	logic                 a_ready;
	b24k_pkg::conv_item_t a_item;
	logic                 b_valid;
	logic                 b_ready;
	b24k_pkg::conv_item_t b_item;

	b24k_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.group_id       (group_id),
		.serial_number  (serial_number),
		.security_value (security_value),
		.upgrade_flag   (upgrade_flag),
		.extra_flag     (extra_flag),
		.out_valid      (f_valid),
		.out_ready      (f_ready),
		.out_item       (f_item)
	);

	b24k_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_item)
	);

	assign a_in.err    = q_item.err;
	assign a_in.bits   = {{TOP_PAD{1'b0}}, q_item.word};
	assign a_in.digits = '0;

	b24k_conv #(
		.STEPS (b24k_pkg::STEPS_A)
	) u_conv_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_item   (a_in),
		.out_valid (a_valid),
		.out_ready (a_ready),
		.out_item  (a_item)
	);

	b24k_conv #(
		.STEPS (b24k_pkg::STEPS_B)
	) u_conv_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (a_valid),
		.in_ready  (a_ready),
		.in_item   (a_item),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_item  (b_item)
	);

	b24k_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (b_valid),
		.in_ready  (b_ready),
		.in_item   (b_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.key_char  (key_char),
		.is_last   (is_last),
		.is_error  (is_error)
	);

	// An error result is a single, empty, final transaction
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_error) |-> (is_last && key_char == b24k_pkg::CH_NONE))
		else $error("error result without is_last or with a character");

	// Every non-error character is non-zero (never CH_NONE)
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_error) |-> (key_char != b24k_pkg::CH_NONE))
		else $error("key character missing");

	// A converted word waits in the second stage until the character stage takes it
	a_conv_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(b_valid && !b_ready) |=> (b_valid && $stable(b_item)))
		else $error("converted word lost before the character stage");

endmodule

// ----- sim/b24k_key_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b24k_key_checker
// Watches both channels of the base-24 key encoder. Every accepted request
// is turned into its 29 key characters (or one error result) and every
// accepted output transaction is compared field by field with the oldest
// pending character. Hands the mismatch count and the number of pending
// characters to the testbench top.
// ----------------------------------------------------------------------------
module b24k_key_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [19:0] group_id,
	input  logic [29:0] serial_number,
	input  logic [52:0] security_value,
	input  logic        upgrade_flag,
	input  logic        extra_flag,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [6:0]  key_char,
	input  logic        is_last,
	input  logic        is_error,
	output int          fail_count,
	output int          outstanding
);

	typedef struct packed {
		logic [6:0] key_char;
		logic       is_last;
		logic       is_error;
	} key_result_t;

	localparam logic [127:0] OVER_LIMIT = {13'h0, 43'h62A_32B1_5518, 72'h0};
	localparam logic [191:0] KEY_ALPHABET = "BCDFGHJKMPQRTVWXY2346789";
	localparam logic [31:0]  CRC32_POLY = 32'h04C1_1DB7;
	localparam logic [6:0]   NO_CHAR = 7'h00;
	localparam logic [6:0]   CHAR_N = 7'h4E;
	localparam logic [6:0]   CHAR_DASH = 7'h2D;
	localparam int           KEY_CHARS = 29;

	key_result_t pending_chars[$];
	int          mismatches;

	initial begin
		mismatches = 0;
	end

	task automatic predict_key(input logic [19:0] grp, input logic [29:0] ser,
			input logic [52:0] sec, input logic upg, input logic ext);
		logic [127:0] word;
		logic [127:0] rest;
		logic [31:0]  crc;
		logic [4:0]   digits [25];
		logic [6:0]   chars [$];
		int           pos;
		word          = '0;
		word[19:0]    = grp;
		word[49:20]   = ser;
		word[102:50]  = sec;
		word[113]     = upg;
		word[114]     = ext;
		// CRC over the 16 bytes, least significant byte first, check field still zero
		crc = 32'hFFFF_FFFF;
		for (int i = 0; i < 16; i++) begin
			crc = crc ^ {word[8*i +: 8], 24'h0};
			for (int b = 0; b < 8; b++) begin
				crc = crc[31] ? ((crc << 1) ^ CRC32_POLY) : (crc << 1);
			end
		end
		word[112:103] = ~crc[9:0];
		if (ext && (word > OVER_LIMIT)) begin
			pending_chars.insert(pending_chars.size(),
				key_result_t'{NO_CHAR, 1'b1, 1'b1});
			return;
		end
		rest = word;
		for (int k = 0; k < 25; k++) begin
			digits[k] = 5'(rest % 128'd24);
			rest      = rest / 128'd24;
		end
		for (int i = 0; i < 24; i++) begin
			chars.insert(chars.size(), KEY_ALPHABET[8*(23 - int'(digits[23-i])) +: 7]);
		end
		pos = int'(digits[24]) % 24;
		chars.insert(pos, CHAR_N);
		for (int i = 0; i < 4; i++) begin
			chars.insert(6*i + 5, CHAR_DASH);
		end
		for (int i = 0; i < KEY_CHARS; i++) begin
			pending_chars.insert(pending_chars.size(),
				key_result_t'{chars[i], (i == KEY_CHARS - 1), 1'b0});
		end
	endtask

	always @(posedge clk) begin
		key_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_key(group_id, serial_number, security_value, upgrade_flag,
					extra_flag);
			end
			if (out_valid && out_ready) begin
				if (pending_chars.size() == 0) begin
					mismatches++;
					$error("unexpected transaction: key_char %h is_last %b is_error %b",
						key_char, is_last, is_error);
				end else begin
					want = pending_chars.pop_front();
					if (key_char !== want.key_char) begin
						mismatches++;
						$error("key_char: expected %h, actual %h", want.key_char, key_char);
					end
					if (is_last !== want.is_last) begin
						mismatches++;
						$error("is_last: expected %b, actual %b", want.is_last, is_last);
					end
					if (is_error !== want.is_error) begin
						mismatches++;
						$error("is_error: expected %b, actual %b", want.is_error, is_error);
					end
				end
			end
		end
		outstanding <= pending_chars.size();
		fail_count  <= mismatches;
	end

endmodule

// ----- sim/base24_key_encoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base24_key_encoder_tb
// Drives key requests into the base-24 key encoder: a directed set of field
// extremes and overflow cases, then random requests in bursts, while the
// receiver stalls on its own pattern including long hold-offs that back the
// block up. A checker beside the block predicts and compares every character.
// ----------------------------------------------------------------------------
module base24_key_encoder_tb;

	localparam int RANDOM_ITEMS = 410;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 150;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [19:0] group_id;
	logic [29:0] serial_number;
	logic [52:0] security_value;
	logic        upgrade_flag;
	logic        extra_flag;
	logic        out_valid;
	logic        out_ready;
	logic [6:0]  key_char;
	logic        is_last;
	logic        is_error;
	int          fail_count;
	int          outstanding;
	int          cycle_count;

	base24_key_encoder DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.group_id       (group_id),
		.serial_number  (serial_number),
		.security_value (security_value),
		.upgrade_flag   (upgrade_flag),
		.extra_flag     (extra_flag),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.key_char       (key_char),
		.is_last        (is_last),
		.is_error       (is_error)
	);

	b24k_key_checker key_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.group_id       (group_id),
		.serial_number  (serial_number),
		.security_value (security_value),
		.upgrade_flag   (upgrade_flag),
		.extra_flag     (extra_flag),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.key_char       (key_char),
		.is_last        (is_last),
		.is_error       (is_error),
		.fail_count     (fail_count),
		.outstanding    (outstanding)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Mostly random values, with zero and all ones mixed in
	function automatic logic [63:0] pick_bits(int unsigned width);
		logic [63:0] mask;
		mask = (64'd1 << width) - 64'd1;
		case ($urandom_range(0, 15))
			0:       return 64'd0;
			1:       return mask;
			default: return {$urandom, $urandom} & mask;
		endcase
	endfunction

	// Present one request and hold it until the transaction completes
	task automatic send_key_request(input logic [19:0] grp, input logic [29:0] ser,
			input logic [52:0] sec, input logic upg, input logic ext);
		@(negedge clk);
		in_valid       <= 1'b1;
		group_id       <= grp;
		serial_number  <= ser;
		security_value <= sec;
		upgrade_flag   <= upg;
		extra_flag     <= ext;
		do @(posedge clk); while (!in_ready);
	endtask

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// Receiver: ready stretches, random stalls and long hold-offs
	initial begin
		int seg;
		int kind;
		int len;
		out_ready = 1'b0;
		seg       = 0;
		wait (arst_n);
		forever begin
			kind = $urandom_range(0, 11);
			if (seg == 8 || kind == 0) begin
				len = $urandom_range(300, 600);
				repeat (len) begin
					@(negedge clk);
					out_ready <= 1'b0;
				end
			end else if (kind < 5) begin
				len = $urandom_range(40, 200);
				repeat (len) begin
					@(negedge clk);
					out_ready <= 1'b1;
				end
			end else begin
				len = $urandom_range(40, 200);
				repeat (len) begin
					@(negedge clk);
					out_ready <= ($urandom_range(0, 3) != 0);
				end
			end
			seg++;
		end
	end

	initial begin
		int sent;
		int burst;
		int gap;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		group_id       = '0;
		serial_number  = '0;
		security_value = '0;
		upgrade_flag   = 1'b0;
		extra_flag     = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Field extremes and single bits
		send_key_request('0, '0, '0, 1'b0, 1'b0);
		send_key_request('1, '1, '1, 1'b0, 1'b0);
		send_key_request('1, '1, '1, 1'b1, 1'b0);
		send_key_request('0, '0, '0, 1'b1, 1'b0);
		send_key_request('0, '0, '0, 1'b0, 1'b1);
		send_key_request('1, '1, '1, 1'b0, 1'b1);
		send_key_request('1, '0, '0, 1'b0, 1'b0);
		send_key_request('0, '1, '0, 1'b0, 1'b0);
		send_key_request('0, '0, '1, 1'b0, 1'b0);
		send_key_request(20'd1, 30'd1, 53'd1, 1'b0, 1'b0);
		send_key_request('0, '0, 53'h10_0000_0000_0000, 1'b1, 1'b0);
		// Both flags set: word lands near the overflow limit
		send_key_request('0, '0, '0, 1'b1, 1'b1);
		send_key_request('1, '1, '1, 1'b1, 1'b1);
		for (int i = 0; i < 8; i++) begin
			send_key_request(20'($urandom), 30'($urandom), 53'({$urandom, $urandom}),
				1'b1, 1'b1);
		end
		@(negedge clk);
		in_valid <= 1'b0;

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 16);
			for (int n = 0; n < burst && sent < RANDOM_ITEMS; n++) begin
				send_key_request(20'(pick_bits(20)), 30'(pick_bits(30)),
					53'(pick_bits(53)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// Let the checker see the last transaction before draining
		@(posedge clk);
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
